// ----- rtl/pox_pkg.sv -----
// ----------------------------------------------------------------------------
// pox_pkg
// Shared types and constants of the pulse oximeter block: fixed-point widths,
// filter constants, register indexes and the serial arithmetic command.
// ----------------------------------------------------------------------------
package pox_pkg;

  // Field and datapath widths
  localparam int SAMPLE_W  = 18;
  localparam int FRAC_W    = 16;
  localparam int LVL_W     = SAMPLE_W + FRAC_W;
  localparam int ENERGY_W  = 56;
  localparam int SQRT_W    = ENERGY_W / 2;
  localparam int ALU_W     = 66;
  localparam int ALU_N_W   = 5;
  localparam int TMP_W     = LVL_W + FRAC_W;
  localparam int M8_W      = LVL_W - 8 + 1;
  localparam int RATE_W    = 16;
  localparam int EST_W     = 16;
  localparam int SAT_W     = 15;
  localparam int TIME_W    = 32;
  localparam int CFG_W     = 18;
  localparam int CFG_IDX_W = 3;
  localparam int WLEN_W    = 11;
  localparam int RATIO_W   = 20;
  localparam int DROP_W    = 25;
  localparam int RAW_W     = 23;

  // Parameter defaults
  localparam int BOOT_MS_DEF    = 3000;
  localparam int WINDOW_MAX_DEF = 1024;

  // Arithmetic constants
  localparam logic [16:0]         ONE_Q16    = 17'd65536;
  localparam logic [15:0]         HALF_Q16   = 16'd32768;
  localparam logic [20:0]         K_SLOPE    = 21'd1526989;
  localparam logic [RAW_W-1:0]    K_OFFSET   = 23'd7164477;
  localparam logic [RAW_W-1:0]    SPO2_CAP   = 23'd6553600;
  localparam logic [EST_W-1:0]    FINGER_OFF = 16'd20480;
  localparam logic [23:0]         BPM_NUM    = 24'd15360000;
  localparam logic [EST_W-1:0]    BPM_MAX    = 16'hFFFF;
  localparam logic [RATIO_W-1:0]  R_MAX      = 20'hFFFFF;
  localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};
  localparam int                  SQRT_TOP   = ENERGY_W - 2;

  // Register reset values
  localparam logic [RATE_W-1:0] DC_RATE_RST     = 16'd62259;
  localparam logic [RATE_W-1:0] SMOOTH_RATE_RST = 16'd55706;
  localparam logic [RATE_W-1:0] BPM_RATE_RST    = 16'd62259;
  localparam logic [RATE_W-1:0] SPO2_RATE_RST   = 16'd45875;
  localparam logic [SAMPLE_W-1:0] FINGER_RST    = 18'd50000;
  localparam logic [WLEN_W-1:0] WLEN_RST        = 11'd100;
  localparam logic [15:0]       MIN_IVL_RST     = 16'd333;
  localparam logic [15:0]       MAX_IVL_RST     = 16'd1333;
  localparam logic [EST_W-1:0]  RATE_EST_RST    = 16'd15360;
  localparam logic [EST_W-1:0]  SAT_EST_RST     = 16'd24320;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DC_RATE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_RATE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BPM_RATE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPO2_RATE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FINGER      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WLEN        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_IVL     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_IVL     = 3'd7;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_SQRT,
    OP_DIV
  } alu_op_t;

  typedef enum logic {
    ALU_IDLE,
    ALU_RUN
  } alu_state_t;

  typedef struct packed {
    alu_op_t            op;
    logic [ALU_W-1:0]   a;
    logic [ALU_W-1:0]   b;
    logic [ALU_W-1:0]   acc;
    logic [ALU_N_W-1:0] n;
  } alu_cmd_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_ISSUE,
    SQ_WAIT,
    SQ_MISC,
    SQ_OUT
  } seq_state_t;

  typedef enum logic [4:0] {
    ST_RED_A,
    ST_RED_B,
    ST_IRDC_A,
    ST_IRDC_B,
    ST_RED_E,
    ST_IR_E,
    ST_SM_A,
    ST_SM_B,
    ST_BPM_DIV,
    ST_BPM_A,
    ST_BPM_B,
    ST_SQ_RED,
    ST_SQ_IR,
    ST_NUM,
    ST_DEN,
    ST_RATIO,
    ST_DROP,
    ST_SAT_A,
    ST_SAT_B
  } step_t;

endpackage

// ----- rtl/pox_if.sv -----
// ----------------------------------------------------------------------------
// pox_in_if / pox_out_if
// Valid/ready channels for sample transactions and result transactions.
// ----------------------------------------------------------------------------
interface pox_in_if;
  logic                         valid;
  logic                         ready;
  logic [pox_pkg::SAMPLE_W-1:0] red_sample;
  logic [pox_pkg::SAMPLE_W-1:0] ir_sample;
  logic [pox_pkg::TIME_W-1:0]   time_ms;

  modport source (output valid, red_sample, ir_sample, time_ms, input ready);
  modport sink (input valid, red_sample, ir_sample, time_ms, output ready);
endinterface

interface pox_out_if;
  logic                      valid;
  logic                      ready;
  logic [pox_pkg::EST_W-1:0] heart_rate;
  logic [pox_pkg::SAT_W-1:0] saturation;
  logic                      saturation_updated;
  logic                      finger_absent;

  modport source (output valid, heart_rate, saturation, saturation_updated, finger_absent,
                  input ready);
  modport sink (input valid, heart_rate, saturation, saturation_updated, finger_absent,
                output ready);
endinterface

// ----- rtl/pox_alu.sv -----
// ----------------------------------------------------------------------------
// pox_alu
// Shared serial arithmetic unit: shift-add multiply-accumulate one multiplier
// bit per cycle, square root two bits per cycle, restoring divide one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module pox_alu (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  pox_pkg::alu_cmd_t            cmd,
  output logic                         done,
  output logic [pox_pkg::ALU_W-1:0]    res
);

  pox_pkg::alu_state_t state, state_next;
  logic                        done_next;
  pox_pkg::alu_op_t            op;
  logic [pox_pkg::ALU_W-1:0]   a;
  logic [pox_pkg::ALU_W-1:0]   b;
  logic [pox_pkg::ALU_W-1:0]   acc;
  logic [pox_pkg::ALU_N_W-1:0] cnt;
  logic                        div_sat;
  logic [pox_pkg::ALU_W-1:0]   root_sum;

  // Quotient would not fit in n bits: answer with the saturation value
  assign div_sat  = {1'b0, cmd.a} >= {cmd.b, 1'b0};
  assign root_sum = acc + b;
  assign res      = acc;

  // Hold state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pox_pkg::ALU_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // Sequence the iterations
  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    unique case (state)
      pox_pkg::ALU_IDLE: begin
        if (start) begin
          if (cmd.op == pox_pkg::OP_DIV && div_sat) begin
            done_next = 1'b1;
          end else begin
            state_next = pox_pkg::ALU_RUN;
          end
        end
      end
      pox_pkg::ALU_RUN: begin
        if (cnt == pox_pkg::ALU_N_W'(1)) begin
          state_next = pox_pkg::ALU_IDLE;
          done_next  = 1'b1;
        end
      end
      default: state_next = pox_pkg::ALU_IDLE;
    endcase
  end

  // Load operands, then advance one digit per cycle
  always_ff @(posedge clk) begin
    if (state == pox_pkg::ALU_IDLE && start) begin
      op  <= cmd.op;
      a   <= cmd.a;
      b   <= cmd.b;
      cnt <= cmd.n;
      acc <= (cmd.op == pox_pkg::OP_DIV && !div_sat) ? '0 : cmd.acc;
    end else if (state == pox_pkg::ALU_RUN) begin
      cnt <= cnt - pox_pkg::ALU_N_W'(1);
      case (op)
        pox_pkg::OP_MUL: begin
          if (b[0]) acc <= acc + a;
          a <= a << 1;
          b <= b >> 1;
        end
        pox_pkg::OP_SQRT: begin
          if (a >= root_sum) begin
            a   <= a - root_sum;
            acc <= (acc >> 1) + b;
          end else begin
            acc <= acc >> 1;
          end
          b <= b >> 2;
        end
        default: begin
          if (a >= b) begin
            a   <= (a - b) << 1;
            acc <= {acc[pox_pkg::ALU_W-2:0], 1'b1};
          end else begin
            a   <= a << 1;
            acc <= {acc[pox_pkg::ALU_W-2:0], 1'b0};
          end
        end
      endcase
    end
  end

endmodule

// ----- rtl/pulse_oximeter_spo2_heart_rate_top.sv -----
// ----------------------------------------------------------------------------
// pulse_oximeter_spo2_heart_rate_top
// SpO2 by ratio of ratios and heart rate by falling zero crossings of a
// smoothed IR signal, one sample transaction at a time.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+------------------------------------
//   in_ch    | in  | valid / ready      | red_sample, ir_sample, time_ms
//   out_ch   | out | valid / ready      | heart_rate, saturation,
//            |     |                    | saturation_updated, finger_absent
//   cfg      | in  | cfg_we, no stall   | cfg_addr, cfg_data
//
// A sample runs as a chain of serial steps of n digits each, issued in SQ_ISSUE
// and awaited in SQ_WAIT. An accepted beat adds the rate divide and its filter
// steps, and a closing window adds the roots, the ratio divide and the SpO2
// steps; a saturating divide skips its iterations. Every multiply, root and
// divide runs through the one serial unit pox_alu, one result bit per cycle.
// Reset is synchronous; it restores the filters and registers, no sweep.
// A new sample is taken while the last result still waits on out_ch; a held
// result stalls only the end of the following sample.
// ----------------------------------------------------------------------------
module pulse_oximeter_spo2_heart_rate_top #(
  parameter int BOOT_MS    = pox_pkg::BOOT_MS_DEF,
  parameter int WINDOW_MAX = pox_pkg::WINDOW_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pox_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [pox_pkg::CFG_W-1:0]     cfg_data,
  pox_in_if.sink                        in_ch,
  pox_out_if.source                     out_ch
);

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int LW    = pox_pkg::LVL_W;
  localparam int AW    = pox_pkg::ALU_W;
  localparam int FW    = pox_pkg::FRAC_W;

  // Configuration registers
  logic [pox_pkg::RATE_W-1:0]   dc_rate, ir_smooth_rate, bpm_rate, spo2_rate;
  logic [pox_pkg::SAMPLE_W-1:0] finger_threshold;
  logic [pox_pkg::WLEN_W-1:0]   window_length;
  logic [15:0]                  min_interval_ms, max_interval_ms;

  // Filter state
  logic [LW-1:0]                red_level, ir_dc_level, ir_smoothed, ir_smoothed_prev;
  logic [pox_pkg::ENERGY_W-1:0] red_energy, ir_energy;
  logic [pox_pkg::TIME_W-1:0]   last_crossing_ms;
  logic [pox_pkg::EST_W-1:0]    rate_estimate, saturation_estimate;
  logic [CNT_W-1:0]             window_count;

  // Per-sample working registers
  logic [LW-1:0]                red_q, ir_q;
  logic [pox_pkg::SAMPLE_W-1:0] ir_raw;
  logic [pox_pkg::TIME_W-1:0]   now;
  logic [pox_pkg::TMP_W-1:0]    tmp;
  logic [15:0]                  gap_ms;
  logic [pox_pkg::EST_W-1:0]    bpm_val;
  logic [pox_pkg::SQRT_W-1:0]   sq_red, sq_ir;
  logic [AW-1:0]                num, den;
  logic [pox_pkg::RATIO_W-1:0]  ratio;
  logic [pox_pkg::SAT_W-1:0]    spo2_raw;
  logic                         updated, absent;

  // Sequencer
  pox_pkg::seq_state_t state, state_next;
  pox_pkg::step_t      step, step_next;
  logic                accept;

  // Output register
  logic                      out_valid;
  logic [pox_pkg::EST_W-1:0] out_rate;
  logic [pox_pkg::SAT_W-1:0] out_sat;
  logic                      out_updated, out_absent;
  logic                      out_free;

  // Arithmetic unit
  pox_pkg::alu_cmd_t cmd;
  logic              alu_start, alu_done;
  logic [AW-1:0]     alu_res;

  // Derived values
  logic [LW-1:0]               red_diff, ir_diff;
  logic [pox_pkg::M8_W-1:0]    red_m8, ir_m8;
  logic [LW-1:0]               iir_new;
  logic                        crossing, gap_ok;
  logic [pox_pkg::TIME_W-1:0]  gap;
  logic [CNT_W-1:0]            win_len, count_inc;
  logic                        win_close;
  logic [pox_pkg::DROP_W-1:0]  drop;
  logic [pox_pkg::RAW_W-1:0]   raw_q16;
  logic [pox_pkg::RAW_W-1:0]   raw_capped;
  logic [pox_pkg::RAW_W:0]     raw_round;

  pox_alu u_alu (
    .clk   (clk),
    .rst   (rst),
    .start (alu_start),
    .cmd   (cmd),
    .done  (alu_done),
    .res   (alu_res)
  );

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state == pox_pkg::SQ_IDLE);
  assign out_free     = !out_valid || out_ch.ready;

  assign out_ch.valid              = out_valid;
  assign out_ch.heart_rate         = out_rate;
  assign out_ch.saturation         = out_sat;
  assign out_ch.saturation_updated = out_updated;
  assign out_ch.finger_absent      = out_absent;

  // AC magnitudes rounded to Q.8
  assign red_diff = (red_q >= red_level) ? red_q - red_level : red_level - red_q;
  assign ir_diff  = (ir_q >= ir_dc_level) ? ir_q - ir_dc_level : ir_dc_level - ir_q;
  assign red_m8   = pox_pkg::M8_W'(({1'b0, red_diff} + (LW + 1)'(128)) >> 8);
  assign ir_m8    = pox_pkg::M8_W'(({1'b0, ir_diff} + (LW + 1)'(128)) >> 8);

  // Filter result of the second multiply of an IIR step
  assign iir_new = alu_res[FW +: LW];

  // Falling crossing of the smoothed IR through the DC level
  assign crossing = (iir_new < ir_dc_level) && (ir_smoothed_prev > ir_dc_level);
  assign gap      = now - last_crossing_ms;
  assign gap_ok   = (gap != '0) && (gap > 32'(min_interval_ms))
                    && (gap < 32'(max_interval_ms));

  // Window length limits
  always_comb begin
    if (window_length == '0) begin
      win_len = CNT_W'(1);
    end else if (32'(window_length) > WINDOW_MAX) begin
      win_len = CNT_W'(WINDOW_MAX);
    end else begin
      win_len = CNT_W'(window_length);
    end
  end
  assign count_inc = window_count + CNT_W'(1);
  assign win_close = count_inc >= win_len;

  // SpO2 from 23.3 R, clamped and rounded to Q7.8
  assign drop       = alu_res[FW +: pox_pkg::DROP_W];
  assign raw_q16    = (drop >= pox_pkg::DROP_W'(pox_pkg::K_OFFSET)) ? '0
                      : pox_pkg::K_OFFSET - pox_pkg::RAW_W'(drop);
  assign raw_capped = (raw_q16 > pox_pkg::SPO2_CAP) ? pox_pkg::SPO2_CAP : raw_q16;
  assign raw_round  = {1'b0, raw_capped} + (pox_pkg::RAW_W + 1)'(128);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dc_rate          <= pox_pkg::DC_RATE_RST;
      ir_smooth_rate   <= pox_pkg::SMOOTH_RATE_RST;
      bpm_rate         <= pox_pkg::BPM_RATE_RST;
      spo2_rate        <= pox_pkg::SPO2_RATE_RST;
      finger_threshold <= pox_pkg::FINGER_RST;
      window_length    <= pox_pkg::WLEN_RST;
      min_interval_ms  <= pox_pkg::MIN_IVL_RST;
      max_interval_ms  <= pox_pkg::MAX_IVL_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pox_pkg::CFG_DC_RATE:     dc_rate          <= cfg_data[15:0];
        pox_pkg::CFG_SMOOTH_RATE: ir_smooth_rate   <= cfg_data[15:0];
        pox_pkg::CFG_BPM_RATE:    bpm_rate         <= cfg_data[15:0];
        pox_pkg::CFG_SPO2_RATE:   spo2_rate        <= cfg_data[15:0];
        pox_pkg::CFG_FINGER:      finger_threshold <= cfg_data;
        pox_pkg::CFG_WLEN:        window_length    <= cfg_data[pox_pkg::WLEN_W-1:0];
        pox_pkg::CFG_MIN_IVL:     min_interval_ms  <= cfg_data[15:0];
        pox_pkg::CFG_MAX_IVL:     max_interval_ms  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Issue the command of the current step
  always_comb begin
    cmd.op  = pox_pkg::OP_MUL;
    cmd.a   = '0;
    cmd.b   = '0;
    cmd.acc = AW'(pox_pkg::HALF_Q16);
    cmd.n   = pox_pkg::ALU_N_W'(16);
    case (step)
      pox_pkg::ST_RED_A: begin
        cmd.a = AW'(red_level);
        cmd.b = AW'(dc_rate);
      end
      pox_pkg::ST_RED_B: begin
        cmd.a   = AW'(red_q);
        cmd.b   = AW'(pox_pkg::ONE_Q16 - 17'(dc_rate));
        cmd.acc = AW'(tmp);
        cmd.n   = pox_pkg::ALU_N_W'(17);
      end
      pox_pkg::ST_IRDC_A: begin
        cmd.a = AW'(ir_dc_level);
        cmd.b = AW'(dc_rate);
      end
      pox_pkg::ST_IRDC_B: begin
        cmd.a   = AW'(ir_q);
        cmd.b   = AW'(pox_pkg::ONE_Q16 - 17'(dc_rate));
        cmd.acc = AW'(tmp);
        cmd.n   = pox_pkg::ALU_N_W'(17);
      end
      pox_pkg::ST_RED_E: begin
        cmd.a   = AW'(red_m8);
        cmd.b   = AW'(red_m8);
        cmd.acc = AW'(red_energy);
        cmd.n   = pox_pkg::ALU_N_W'(pox_pkg::M8_W);
      end
      pox_pkg::ST_IR_E: begin
        cmd.a   = AW'(ir_m8);
        cmd.b   = AW'(ir_m8);
        cmd.acc = AW'(ir_energy);
        cmd.n   = pox_pkg::ALU_N_W'(pox_pkg::M8_W);
      end
      pox_pkg::ST_SM_A: begin
        cmd.a = AW'(ir_smoothed);
        cmd.b = AW'(ir_smooth_rate);
      end
      pox_pkg::ST_SM_B: begin
        cmd.a   = AW'(ir_q);
        cmd.b   = AW'(pox_pkg::ONE_Q16 - 17'(ir_smooth_rate));
        cmd.acc = AW'(tmp);
        cmd.n   = pox_pkg::ALU_N_W'(17);
      end
      pox_pkg::ST_BPM_DIV: begin
        cmd.op  = pox_pkg::OP_DIV;
        cmd.a   = AW'(pox_pkg::BPM_NUM) + AW'(gap_ms >> 1);
        cmd.b   = AW'(gap_ms) << 15;
        cmd.acc = AW'(pox_pkg::BPM_MAX);
      end
      pox_pkg::ST_BPM_A: begin
        cmd.a = AW'(rate_estimate);
        cmd.b = AW'(bpm_rate);
      end
      pox_pkg::ST_BPM_B: begin
        cmd.a   = AW'(bpm_val);
        cmd.b   = AW'(pox_pkg::ONE_Q16 - 17'(bpm_rate));
        cmd.acc = AW'(tmp);
        cmd.n   = pox_pkg::ALU_N_W'(17);
      end
      pox_pkg::ST_SQ_RED: begin
        cmd.op  = pox_pkg::OP_SQRT;
        cmd.a   = AW'(red_energy);
        cmd.b   = AW'(1) << pox_pkg::SQRT_TOP;
        cmd.acc = '0;
        cmd.n   = pox_pkg::ALU_N_W'(pox_pkg::SQRT_W);
      end
      pox_pkg::ST_SQ_IR: begin
        cmd.op  = pox_pkg::OP_SQRT;
        cmd.a   = AW'(ir_energy);
        cmd.b   = AW'(1) << pox_pkg::SQRT_TOP;
        cmd.acc = '0;
        cmd.n   = pox_pkg::ALU_N_W'(pox_pkg::SQRT_W);
      end
      pox_pkg::ST_NUM: begin
        cmd.a   = AW'(ir_dc_level);
        cmd.b   = AW'(sq_red);
        cmd.acc = '0;
        cmd.n   = pox_pkg::ALU_N_W'(pox_pkg::SQRT_W);
      end
      pox_pkg::ST_DEN: begin
        cmd.a   = AW'(red_level);
        cmd.b   = AW'(sq_ir);
        cmd.acc = '0;
        cmd.n   = pox_pkg::ALU_N_W'(pox_pkg::SQRT_W);
      end
      pox_pkg::ST_RATIO: begin
        cmd.op  = pox_pkg::OP_DIV;
        cmd.a   = num;
        cmd.b   = den << 3;
        cmd.acc = AW'(pox_pkg::R_MAX);
        cmd.n   = pox_pkg::ALU_N_W'(pox_pkg::RATIO_W);
      end
      pox_pkg::ST_DROP: begin
        cmd.a = AW'(pox_pkg::K_SLOPE);
        cmd.b = AW'(ratio);
        cmd.n = pox_pkg::ALU_N_W'(pox_pkg::RATIO_W);
      end
      pox_pkg::ST_SAT_A: begin
        cmd.a = AW'(saturation_estimate);
        cmd.b = AW'(spo2_rate);
      end
      pox_pkg::ST_SAT_B: begin
        cmd.a   = AW'(spo2_raw);
        cmd.b   = AW'(pox_pkg::ONE_Q16 - 17'(spo2_rate));
        cmd.acc = AW'(tmp);
        cmd.n   = pox_pkg::ALU_N_W'(17);
      end
      default: ;
    endcase
  end

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pox_pkg::SQ_IDLE;
      step  <= pox_pkg::ST_RED_A;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // Next state and step
  always_comb begin
    state_next = state;
    step_next  = step;
    alu_start  = 1'b0;
    unique case (state)
      pox_pkg::SQ_IDLE: begin
        if (accept) begin
          state_next = pox_pkg::SQ_ISSUE;
          step_next  = pox_pkg::ST_RED_A;
        end
      end
      pox_pkg::SQ_ISSUE: begin
        alu_start  = 1'b1;
        state_next = pox_pkg::SQ_WAIT;
      end
      pox_pkg::SQ_WAIT: begin
        if (alu_done) begin
          state_next = pox_pkg::SQ_ISSUE;
          unique case (step)
            pox_pkg::ST_RED_A:   step_next = pox_pkg::ST_RED_B;
            pox_pkg::ST_RED_B:   step_next = pox_pkg::ST_IRDC_A;
            pox_pkg::ST_IRDC_A:  step_next = pox_pkg::ST_IRDC_B;
            pox_pkg::ST_IRDC_B:  step_next = pox_pkg::ST_RED_E;
            pox_pkg::ST_RED_E:   step_next = pox_pkg::ST_IR_E;
            pox_pkg::ST_IR_E:    step_next = pox_pkg::ST_SM_A;
            pox_pkg::ST_SM_A:    step_next = pox_pkg::ST_SM_B;
            pox_pkg::ST_SM_B: begin
              if (crossing && gap_ok) begin
                step_next = pox_pkg::ST_BPM_DIV;
              end else begin
                state_next = pox_pkg::SQ_MISC;
              end
            end
            pox_pkg::ST_BPM_DIV: step_next  = pox_pkg::ST_BPM_A;
            pox_pkg::ST_BPM_A:   step_next  = pox_pkg::ST_BPM_B;
            pox_pkg::ST_BPM_B:   state_next = pox_pkg::SQ_MISC;
            pox_pkg::ST_SQ_RED:  step_next  = pox_pkg::ST_SQ_IR;
            pox_pkg::ST_SQ_IR:   step_next  = pox_pkg::ST_NUM;
            pox_pkg::ST_NUM:     step_next  = pox_pkg::ST_DEN;
            pox_pkg::ST_DEN:     step_next  = pox_pkg::ST_RATIO;
            pox_pkg::ST_RATIO:   step_next  = pox_pkg::ST_DROP;
            pox_pkg::ST_DROP:    step_next  = pox_pkg::ST_SAT_A;
            pox_pkg::ST_SAT_A:   step_next  = pox_pkg::ST_SAT_B;
            pox_pkg::ST_SAT_B:   state_next = pox_pkg::SQ_OUT;
            default:             state_next = pox_pkg::SQ_OUT;
          endcase
        end
      end
      pox_pkg::SQ_MISC: begin
        if (win_close) begin
          state_next = pox_pkg::SQ_ISSUE;
          step_next  = pox_pkg::ST_SQ_RED;
        end else begin
          state_next = pox_pkg::SQ_OUT;
        end
      end
      pox_pkg::SQ_OUT: begin
        if (out_free) state_next = pox_pkg::SQ_IDLE;
      end
      default: state_next = pox_pkg::SQ_IDLE;
    endcase
  end

  // Latch the sample transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      red_q  <= {in_ch.red_sample, FW'(0)};
      ir_q   <= {in_ch.ir_sample, FW'(0)};
      ir_raw <= in_ch.ir_sample;
      now    <= in_ch.time_ms;
    end
  end

  // Commit step results to the filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      red_level           <= '0;
      ir_dc_level         <= '0;
      red_energy          <= '0;
      ir_energy           <= '0;
      ir_smoothed         <= '0;
      ir_smoothed_prev    <= '0;
      last_crossing_ms    <= '0;
      rate_estimate       <= pox_pkg::RATE_EST_RST;
      saturation_estimate <= pox_pkg::SAT_EST_RST;
      window_count        <= '0;
      updated             <= 1'b0;
      absent              <= 1'b0;
    end else begin
      if (accept) begin
        updated <= 1'b0;
        absent  <= 1'b0;
      end
      if (state == pox_pkg::SQ_WAIT && alu_done) begin
        case (step)
          pox_pkg::ST_RED_A, pox_pkg::ST_IRDC_A, pox_pkg::ST_SM_A,
          pox_pkg::ST_BPM_A, pox_pkg::ST_SAT_A: begin
            tmp <= alu_res[pox_pkg::TMP_W-1:0];
          end
          pox_pkg::ST_RED_B:  red_level   <= iir_new;
          pox_pkg::ST_IRDC_B: ir_dc_level <= iir_new;
          pox_pkg::ST_RED_E: begin
            red_energy <= (alu_res > AW'(pox_pkg::ENERGY_MAX)) ? pox_pkg::ENERGY_MAX
                          : alu_res[pox_pkg::ENERGY_W-1:0];
          end
          pox_pkg::ST_IR_E: begin
            ir_energy <= (alu_res > AW'(pox_pkg::ENERGY_MAX)) ? pox_pkg::ENERGY_MAX
                         : alu_res[pox_pkg::ENERGY_W-1:0];
          end
          pox_pkg::ST_SM_B: begin
            ir_smoothed      <= iir_new;
            ir_smoothed_prev <= iir_new;
            gap_ms           <= gap[15:0];
            if (crossing) last_crossing_ms <= now;
          end
          pox_pkg::ST_BPM_DIV: bpm_val       <= alu_res[pox_pkg::EST_W-1:0];
          pox_pkg::ST_BPM_B:   rate_estimate <= alu_res[FW +: pox_pkg::EST_W];
          pox_pkg::ST_SQ_RED:  sq_red        <= alu_res[pox_pkg::SQRT_W-1:0];
          pox_pkg::ST_SQ_IR:   sq_ir         <= alu_res[pox_pkg::SQRT_W-1:0];
          pox_pkg::ST_NUM:     num           <= alu_res;
          pox_pkg::ST_DEN:     den           <= alu_res;
          pox_pkg::ST_RATIO:   ratio         <= alu_res[pox_pkg::RATIO_W-1:0];
          pox_pkg::ST_DROP:    spo2_raw      <= raw_round[8 +: pox_pkg::SAT_W];
          pox_pkg::ST_SAT_B: begin
            saturation_estimate <= alu_res[FW +: pox_pkg::EST_W];
            red_energy          <= '0;
            ir_energy           <= '0;
            window_count        <= '0;
            updated             <= 1'b1;
          end
          default: ;
        endcase
      end
      // Finger test, then advance the window count
      if (state == pox_pkg::SQ_MISC) begin
        if (now > 32'(BOOT_MS) && ir_raw < finger_threshold) begin
          saturation_estimate <= pox_pkg::FINGER_OFF;
          absent              <= 1'b1;
        end
        if (!win_close) window_count <= count_inc;
      end
    end
  end

  // Output register: drop on take, load when the sample finishes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == pox_pkg::SQ_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == pox_pkg::SQ_OUT && out_free) begin
      out_rate    <= rate_estimate;
      out_sat     <= saturation_estimate[pox_pkg::SAT_W-1:0];
      out_updated <= updated;
      out_absent  <= absent;
    end
  end

endmodule
